FILE: hdl/gshare_tournament_branch_predictor_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the branch predictor core
// Implication checks on a clock with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef GSHARE_TOURNAMENT_BRANCH_PREDICTOR_CORE_ASSERT_SVH
`define GSHARE_TOURNAMENT_BRANCH_PREDICTOR_CORE_ASSERT_SVH

// same-cycle implication
`define GTBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gtbp assertion failed");

// next-cycle implication
`define GTBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gtbp assertion failed");

`endif

FILE: hdl/gtbp_pkg.sv
// ----------------------------------------------------------------------------
// gtbp_pkg
// Shared types, codes and helper functions of the branch predictor core.
// ----------------------------------------------------------------------------
package gtbp_pkg;

    // predictor modes
    typedef enum logic [1:0] {
        MODE_STATIC = 2'd0,
        MODE_GSHARE = 2'd1,
        MODE_TOURN  = 2'd2,
        MODE_RSVD   = 2'd3
    } t_mode;

    // operation codes of an input word
    typedef enum logic {
        OP_PREDICT = 1'b0,
        OP_TRAIN   = 1'b1
    } t_op;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_MODE  = 2'd0,
        CFG_GBITS = 2'd1,
        CFG_LBITS = 2'd2,
        CFG_PBITS = 2'd3
    } t_cfg_idx;

    // controller states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOC,
        S_EXEC
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr;     // table clearing write this cycle
        logic accept;  // input word taken, first table reads
        logic rd_loc;  // local counter read
        logic exec;    // evaluate, update tables, load result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;   // clearing pass at its last entry
        logic out_block;  // result register full and not drained, current word a predict
    } t_status;

    localparam int unsigned CFG_W      = 4;
    localparam logic [1:0]  CTR_WEAK_NT = 2'd1;
    localparam t_mode       RST_MODE   = MODE_GSHARE;
    localparam logic [3:0]  RST_GBITS  = 4'd13;
    localparam logic [3:0]  RST_LBITS  = 4'd10;
    localparam logic [3:0]  RST_PBITS  = 4'd10;

    // low-bit mask of a width register, clamped to a maximum
    function automatic logic [31:0] f_width_mask(input logic [3:0] bits,
                                                 input int unsigned max_bits);
        logic [4:0] b;
        begin
            if (32'(bits) > max_bits) begin
                b = 5'(max_bits);
            end else begin
                b = {1'b0, bits};
            end
            return (32'd1 << b) - 32'd1;
        end
    endfunction

    // 2-bit saturating counter step
    function automatic logic [1:0] f_bump(input logic [1:0] ctr, input logic up);
        begin
            if (up) begin
                return (ctr == 2'd3) ? ctr : ctr + 2'd1;
            end else begin
                return (ctr == 2'd0) ? ctr : ctr - 2'd1;
            end
        end
    endfunction

endpackage

FILE: hdl/gshare_tournament_branch_predictor_core.sv
// Each word runs through accept (history/global/chooser reads), local counter
// read, then evaluate and table update; the local counter read waits on the local history read.
// A prediction result shows on o_out_valid the cycle after evaluation; a full,
// undrained result register holds the evaluation of a predict word in place.
// After reset a clearing pass over all table entries runs before the first word is taken.
`include "gshare_tournament_branch_predictor_core_assert.svh"
// ----------------------------------------------------------------------------
// gshare_tournament_branch_predictor_core
// Static / gshare / tournament conditional branch predictor.
// ----------------------------------------------------------------------------
module gshare_tournament_branch_predictor_core #(
    parameter int unsigned GLOBAL_HISTORY_MAX = 13,
    parameter int unsigned LOCAL_HISTORY_MAX  = 11,
    parameter int unsigned PC_INDEX_MAX       = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [31:0] i_branch_pc,
    input  logic        i_actual_outcome,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_predict_taken
);

    gtbp_pkg::t_cmd    cmd;
    gtbp_pkg::t_status status;

    // sequencer
    gtbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    // tables and result
    gtbp_dp #(
        .GLOBAL_HISTORY_MAX (GLOBAL_HISTORY_MAX),
        .LOCAL_HISTORY_MAX  (LOCAL_HISTORY_MAX),
        .PC_INDEX_MAX       (PC_INDEX_MAX)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_operation      (i_operation),
        .i_branch_pc      (i_branch_pc),
        .i_actual_outcome (i_actual_outcome),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_predict_taken  (o_predict_taken)
    );

    // predict word taken on the input channel
    logic pred_acc;
    assign pred_acc = i_in_valid && o_in_ready && (i_operation == gtbp_pkg::OP_PREDICT);

    // assertions
    `GTBP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `GTBP_ASSERT_NOW(a_result_from_predict, i_clk, i_rst_n, $rose(o_out_valid), $past(pred_acc, 3))
    `GTBP_ASSERT_NOW(a_one_step_cmd, i_clk, i_rst_n, 1'b1, $onehot0(cmd))

endmodule

FILE: hdl/gtbp_ctrl.sv
// ----------------------------------------------------------------------------
// gtbp_ctrl
// Sequencer: table clearing after reset, then accept / local read / execute.
// ----------------------------------------------------------------------------
module gtbp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  gtbp_pkg::t_status  i_status,
    output gtbp_pkg::t_cmd     o_cmd,
    output logic               o_in_ready
);

    gtbp_pkg::t_state r_state;
    gtbp_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gtbp_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gtbp_pkg::S_CLEAR: begin
                if (i_status.clr_last) n_state = gtbp_pkg::S_IDLE;
            end
            gtbp_pkg::S_IDLE: begin
                if (i_in_valid) n_state = gtbp_pkg::S_LOC;
            end
            gtbp_pkg::S_LOC: begin
                n_state = gtbp_pkg::S_EXEC;
            end
            gtbp_pkg::S_EXEC: begin
                if (!i_status.out_block) n_state = gtbp_pkg::S_IDLE;
            end
            default: n_state = gtbp_pkg::S_CLEAR;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            gtbp_pkg::S_CLEAR: o_cmd.clr = 1'b1;
            gtbp_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            gtbp_pkg::S_LOC:  o_cmd.rd_loc = 1'b1;
            gtbp_pkg::S_EXEC: o_cmd.exec = !i_status.out_block;
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: hdl/gtbp_dp.sv
// ----------------------------------------------------------------------------
// gtbp_dp
// Predictor datapath: config registers, histories, counter tables and the
// result register.
// ----------------------------------------------------------------------------
module gtbp_dp #(
    parameter int unsigned GLOBAL_HISTORY_MAX = 13,
    parameter int unsigned LOCAL_HISTORY_MAX  = 11,
    parameter int unsigned PC_INDEX_MAX       = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  gtbp_pkg::t_cmd          i_cmd,
    output gtbp_pkg::t_status       o_status,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_index,
    input  logic [gtbp_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                    i_operation,
    input  logic [31:0]             i_branch_pc,
    input  logic                    i_actual_outcome,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic                    o_predict_taken
);

    localparam int unsigned GH = GLOBAL_HISTORY_MAX;
    localparam int unsigned LH = LOCAL_HISTORY_MAX;
    localparam int unsigned PW = PC_INDEX_MAX;
    localparam int unsigned CLR_W0 = (GH > LH) ? GH : LH;
    localparam int unsigned CLR_W  = (CLR_W0 > PW) ? CLR_W0 : PW;

    // configuration
    gtbp_pkg::t_mode r_mode;
    logic [3:0]      r_gbits, r_lbits, r_pbits;

    // histories, guesses, clearing
    logic [GH-1:0]    r_ghist, n_ghist;
    logic             r_last_local, r_last_global;
    logic [CLR_W-1:0] r_clr_cnt;

    // word captured at accept, local index at the local read
    logic             r_op, r_outcome;
    logic [GH-1:0]    r_gidx;
    logic [PW-1:0]    r_pidx;
    logic [LH-1:0]    r_lidx;

    // tables and registered read data
    logic [1:0]    mem_gctr  [2**GH];
    logic [1:0]    mem_chs   [2**GH];
    logic [LH-1:0] mem_lhist [2**PW];
    logic [1:0]    mem_lctr  [2**LH];
    logic [1:0]    r_gctr_q, r_chs_q, r_lctr_q;
    logic [LH-1:0] r_lhist_q;

    // result register
    logic r_out_valid, r_out_taken;

    // masks from width registers
    logic [GH-1:0] gmask;
    logic [LH-1:0] lmask;
    logic [PW-1:0] pmask;
    logic [31:0]   gmask_w, lmask_w, pmask_w;
    always_comb begin
        gmask_w = gtbp_pkg::f_width_mask(r_gbits, GH);
        lmask_w = gtbp_pkg::f_width_mask(r_lbits, LH);
        pmask_w = gtbp_pkg::f_width_mask(r_pbits, PW);
        gmask   = gmask_w[GH-1:0];
        lmask   = lmask_w[LH-1:0];
        pmask   = pmask_w[PW-1:0];
    end

    // read addresses: first stage from the incoming word, local counters from the local history
    logic [GH-1:0] gidx_acc;
    logic [PW-1:0] pidx_acc;
    logic [LH-1:0] lidx_loc;
    always_comb begin
        if (r_mode == gtbp_pkg::MODE_GSHARE) begin
            gidx_acc = (r_ghist ^ i_branch_pc[GH-1:0]) & gmask;
        end else begin
            gidx_acc = r_ghist & gmask;
        end
        pidx_acc = i_branch_pc[PW-1:0] & pmask;
        lidx_loc = r_lhist_q & lmask;
    end

    // execute-stage decode
    logic is_train, is_pred, upd_g, upd_t;
    logic pred;
    logic [GH:0] gs_shift, gt_shift;
    logic [LH:0] lh_shift;
    always_comb begin
        is_train = i_cmd.exec && (r_op == gtbp_pkg::OP_TRAIN);
        is_pred  = i_cmd.exec && (r_op == gtbp_pkg::OP_PREDICT);
        upd_g    = is_train && (r_mode == gtbp_pkg::MODE_GSHARE);
        upd_t    = is_train && (r_mode == gtbp_pkg::MODE_TOURN);
        gs_shift = {r_ghist, r_outcome};
        gt_shift = {r_gidx, r_outcome};
        lh_shift = {r_lidx, r_outcome};
        case (r_mode)
            gtbp_pkg::MODE_STATIC: pred = 1'b1;
            gtbp_pkg::MODE_GSHARE: pred = r_gctr_q[1];
            gtbp_pkg::MODE_TOURN:  pred = r_chs_q[1] ? r_lctr_q[1] : r_gctr_q[1];
            default:               pred = 1'b0;
        endcase
        if (upd_g) begin
            n_ghist = gs_shift[GH-1:0];
        end else if (upd_t) begin
            n_ghist = gt_shift[GH-1:0] & gmask;
        end else begin
            n_ghist = r_ghist;
        end
    end

    // table write ports: clearing pass or training update
    logic          gctr_we, chs_we, lhist_we, lctr_we;
    logic [GH-1:0] gctr_wa;
    logic [PW-1:0] lhist_wa;
    logic [LH-1:0] lctr_wa;
    logic [1:0]    gctr_wd, chs_wd, lctr_wd;
    logic [LH-1:0] lhist_wd;
    always_comb begin
        gctr_we  = i_cmd.clr || upd_g || upd_t;
        chs_we   = i_cmd.clr || (upd_t && (r_last_local != r_last_global));
        lhist_we = i_cmd.clr || upd_t;
        lctr_we  = i_cmd.clr || upd_t;
        if (i_cmd.clr) begin
            gctr_wa  = r_clr_cnt[GH-1:0];
            lhist_wa = r_clr_cnt[PW-1:0];
            lctr_wa  = r_clr_cnt[LH-1:0];
            gctr_wd  = gtbp_pkg::CTR_WEAK_NT;
            chs_wd   = gtbp_pkg::CTR_WEAK_NT;
            lctr_wd  = gtbp_pkg::CTR_WEAK_NT;
            lhist_wd = '0;
        end else begin
            gctr_wa  = r_gidx;
            lhist_wa = r_pidx;
            lctr_wa  = r_lidx;
            gctr_wd  = gtbp_pkg::f_bump(r_gctr_q, r_outcome);
            chs_wd   = gtbp_pkg::f_bump(r_chs_q, r_last_local == r_outcome);
            lctr_wd  = gtbp_pkg::f_bump(r_lctr_q, r_outcome);
            lhist_wd = lh_shift[LH-1:0] & lmask;
        end
    end

    // global counters
    always_ff @(posedge i_clk) begin
        if (gctr_we) mem_gctr[gctr_wa] <= gctr_wd;
        if (i_cmd.accept) r_gctr_q <= mem_gctr[gidx_acc];
    end

    // chooser counters, same index as global counters
    always_ff @(posedge i_clk) begin
        if (chs_we) mem_chs[gctr_wa] <= chs_wd;
        if (i_cmd.accept) r_chs_q <= mem_chs[gidx_acc];
    end

    // local history table
    always_ff @(posedge i_clk) begin
        if (lhist_we) mem_lhist[lhist_wa] <= lhist_wd;
        if (i_cmd.accept) r_lhist_q <= mem_lhist[pidx_acc];
    end

    // local counters, read in the cycle after accept, indexed by the local history
    always_ff @(posedge i_clk) begin
        if (lctr_we) mem_lctr[lctr_wa] <= lctr_wd;
        if (i_cmd.rd_loc) r_lctr_q <= mem_lctr[lidx_loc];
    end

    // captured word
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op      <= i_operation;
            r_outcome <= i_actual_outcome;
            r_gidx    <= gidx_acc;
            r_pidx    <= pidx_acc;
        end
        if (i_cmd.rd_loc) r_lidx <= lidx_loc;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= gtbp_pkg::RST_MODE;
            r_gbits <= gtbp_pkg::RST_GBITS;
            r_lbits <= gtbp_pkg::RST_LBITS;
            r_pbits <= gtbp_pkg::RST_PBITS;
        end else if (i_cfg_we) begin
            case (gtbp_pkg::t_cfg_idx'(i_cfg_index))
                gtbp_pkg::CFG_MODE:  r_mode  <= gtbp_pkg::t_mode'(i_cfg_wdata[1:0]);
                gtbp_pkg::CFG_GBITS: r_gbits <= i_cfg_wdata;
                gtbp_pkg::CFG_LBITS: r_lbits <= i_cfg_wdata;
                gtbp_pkg::CFG_PBITS: r_pbits <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // histories, recorded guesses, clearing counter, result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ghist       <= '0;
            r_last_local  <= 1'b0;
            r_last_global <= 1'b0;
            r_clr_cnt     <= '0;
            r_out_valid   <= 1'b0;
            r_out_taken   <= 1'b0;
        end else begin
            r_ghist <= n_ghist;
            if (i_cmd.clr) r_clr_cnt <= r_clr_cnt + CLR_W'(1);
            if (is_pred && (r_mode == gtbp_pkg::MODE_GSHARE)) begin
                r_last_global <= r_gctr_q[1];
            end else if (is_pred && (r_mode == gtbp_pkg::MODE_TOURN)) begin
                r_last_global <= r_gctr_q[1];
                r_last_local  <= r_lctr_q[1];
            end
            if (is_pred) begin
                r_out_valid <= 1'b1;
                r_out_taken <= pred;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.clr_last  = &r_clr_cnt;
        o_status.out_block = (r_op == gtbp_pkg::OP_PREDICT) && r_out_valid && !i_out_ready;
        o_out_valid        = r_out_valid;
        o_predict_taken    = r_out_taken;
    end

endmodule
